### rtl/sarl_pkg.sv
// Shared constants, types and codes for the sorted address range lookup.
package sarl_pkg;

  localparam int unsigned TABLE_DEPTH = 65536;
  localparam int unsigned INDEX_BITS  = $clog2(TABLE_DEPTH);
  localparam int unsigned COUNT_BITS  = INDEX_BITS + 1;
  localparam int unsigned HANDLE_BITS = 20;
  localparam int unsigned ADDR_BITS   = 64;
  localparam int unsigned SPAN_BITS   = 32;

  typedef logic [ADDR_BITS-1:0]   addr_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;
  typedef logic [INDEX_BITS-1:0]  index_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [SPAN_BITS-1:0]   span_t;

  localparam span_t TAIL_SPAN_RESET = 32'h0000_ffff;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_LOADED        = 3'd0,
    ST_NOT_ASCENDING = 3'd1,
    ST_FULL          = 3'd2,
    ST_FOUND         = 3'd3,
    ST_NOT_KERNEL    = 3'd4,
    ST_OUTSIDE       = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_PROBE,
    S_COMPARE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    wr_en;
    index_t  wr_index;
    addr_t   wr_start;
    handle_t wr_handle;
    logic    rd_en;
    index_t  rd_index;
  } tbl_ctrl_t;

endpackage

### rtl/sarl_if.sv
// Request, response and configuration channel interfaces.
interface sarl_req_if;
  logic              valid;
  logic              ready;
  logic              opcode;
  sarl_pkg::addr_t   address;
  sarl_pkg::handle_t name_handle;
  logic              kernel_context;

  modport source(output valid, opcode, address, name_handle, kernel_context, input ready);
  modport sink(input valid, opcode, address, name_handle, kernel_context, output ready);
endinterface

interface sarl_rsp_if;
  logic                valid;
  logic                ready;
  sarl_pkg::status_t   status;
  sarl_pkg::handle_t   found_handle;
  sarl_pkg::addr_t     range_start;
  sarl_pkg::addr_t     range_end;

  modport source(output valid, status, found_handle, range_start, range_end, input ready);
  modport sink(input valid, status, found_handle, range_start, range_end, output ready);
endinterface

interface sarl_cfg_if;
  logic            valid;
  logic            ready;
  sarl_pkg::span_t data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

### rtl/sorted_address_range_lookup.sv
// Sorted address range lookup: symbol table load and interval search by binary search.
//
// A load request or a lookup that is rejected (wrong context) is answered from the idle state.
// A lookup first runs the range check, then one probe per search step in the
// states S_PROBE (table address out) and S_COMPARE (registered read data
// compared), then forms the range end in S_FINISH. The single read port of the
// table memory sets the probe rate. A waiting result holds off the next request;
// no clearing pass follows reset.
module sorted_address_range_lookup (
  input logic        clk,
  input logic        rst,
  sarl_cfg_if.sink   cfg,
  sarl_req_if.sink   req,
  sarl_rsp_if.source rsp
);
  import sarl_pkg::*;

  state_t    state;
  state_t    state_next;
  span_t     tail_span;
  count_t    entry_count;
  addr_t     prev_addr;
  addr_t     first_start;
  addr_t     last_start;
  addr_t     query_addr;
  count_t    lo;
  count_t    hi;
  addr_t     best_start;
  handle_t   best_handle;
  addr_t     next_start;

  logic      rsp_valid;
  status_t   rsp_status;
  handle_t   rsp_handle;
  addr_t     rsp_start;
  addr_t     rsp_end;

  tbl_ctrl_t tbl_ctrl;
  addr_t     rd_start;
  handle_t   rd_handle;

  logic                out_free;
  logic                req_fire;
  logic [COUNT_BITS:0] mid_sum;
  count_t              mid;
  addr_t               high_bound;
  logic                in_range;
  logic                probe_le;
  count_t              lo_upd;
  count_t              hi_upd;
  addr_t               end_calc;
  logic                load_ascending;
  logic                load_full;

  logic                emit;
  status_t             emit_status;
  logic                emit_found;
  logic                load_keep;

  sarl_table u_table (
    .clk      (clk),
    .ctrl     (tbl_ctrl),
    .rd_start (rd_start),
    .rd_handle(rd_handle)
  );

  assign cfg.ready  = 1'b1;
  assign out_free   = !rsp_valid || rsp.ready;
  assign req.ready  = (state == S_IDLE) && out_free;
  assign req_fire   = req.valid && req.ready;

  assign mid_sum    = {1'b0, lo} + {1'b0, hi};
  assign mid        = mid_sum[COUNT_BITS:1];
  assign high_bound = last_start + ADDR_BITS'(tail_span);
  assign in_range   = (entry_count != '0) && (query_addr >= first_start) &&
                      (query_addr < high_bound);
  assign probe_le   = rd_start <= query_addr;
  assign lo_upd     = probe_le ? mid + count_t'(1) : lo;
  assign hi_upd     = probe_le ? hi : mid;
  assign end_calc   = (hi == entry_count) ? best_start + ADDR_BITS'(tail_span) : next_start;

  assign load_ascending = req.address > prev_addr;
  assign load_full      = entry_count >= COUNT_BITS'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next        = state;
    emit              = 1'b0;
    emit_status       = ST_LOADED;
    emit_found        = 1'b0;
    load_keep         = 1'b0;
    tbl_ctrl.wr_en    = 1'b0;
    tbl_ctrl.wr_index = entry_count[INDEX_BITS-1:0];
    tbl_ctrl.wr_start = req.address;
    tbl_ctrl.wr_handle = req.name_handle;
    tbl_ctrl.rd_en    = 1'b0;
    tbl_ctrl.rd_index = mid[INDEX_BITS-1:0];
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          if (req.opcode == OP_LOAD) begin
            emit = 1'b1;
            if (!load_ascending) begin
              emit_status = ST_NOT_ASCENDING;
            end else if (load_full) begin
              emit_status = ST_FULL;
            end else begin
              emit_status    = ST_LOADED;
              load_keep      = 1'b1;
              tbl_ctrl.wr_en = 1'b1;
            end
          end else if (!req.kernel_context) begin
            emit        = 1'b1;
            emit_status = ST_NOT_KERNEL;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (!in_range) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = ST_OUTSIDE;
            state_next  = S_IDLE;
          end
        end else begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        tbl_ctrl.rd_en = 1'b1;
        state_next     = S_COMPARE;
      end
      S_COMPARE: begin
        state_next = (lo_upd < hi_upd) ? S_PROBE : S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = ST_FOUND;
          emit_found  = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_span <= TAIL_SPAN_RESET;
    end else if (cfg.valid) begin
      tail_span <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      prev_addr   <= '0;
    end else if (req_fire && req.opcode == OP_LOAD) begin
      prev_addr <= req.address;
      if (load_keep) begin
        entry_count <= entry_count + count_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_keep) begin
      last_start <= req.address;
      if (entry_count == '0) begin
        first_start <= req.address;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      query_addr <= req.address;
    end
    if (state == S_CHECK) begin
      lo <= '0;
      hi <= entry_count;
    end else if (state == S_COMPARE) begin
      lo <= lo_upd;
      hi <= hi_upd;
      if (probe_le) begin
        best_start  <= rd_start;
        best_handle <= rd_handle;
      end else begin
        next_start <= rd_start;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp_status <= emit_status;
      rsp_handle <= emit_found ? best_handle : '0;
      rsp_start  <= emit_found ? best_start : '0;
      rsp_end    <= emit_found ? end_calc : '0;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.found_handle = rsp_handle;
  assign rsp.range_start  = rsp_start;
  assign rsp.range_end    = rsp_end;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= COUNT_BITS'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_probe_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (lo < hi) && (hi <= entry_count))
    else $error("search window empty or beyond table");

  a_compare_after_probe: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMPARE) |-> ($past(state) == S_PROBE))
    else $error("compare without a table read");

  a_load_answers: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.opcode == OP_LOAD) |=> rsp_valid && (state == S_IDLE))
    else $error("load request did not produce a response");

  a_no_write_in_search: assert property (@(posedge clk) disable iff (rst)
    tbl_ctrl.wr_en |-> (state == S_IDLE) && !tbl_ctrl.rd_en)
    else $error("table write outside idle");
`endif

endmodule

### rtl/sarl_table.sv
// Symbol table memory: start addresses and name handles, one write and one registered read port.
module sarl_table (
  input  logic                clk,
  input  sarl_pkg::tbl_ctrl_t ctrl,
  output sarl_pkg::addr_t     rd_start,
  output sarl_pkg::handle_t   rd_handle
);
  import sarl_pkg::*;

  addr_t   start_mem  [TABLE_DEPTH];
  handle_t handle_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      start_mem[ctrl.wr_index]  <= ctrl.wr_start;
      handle_mem[ctrl.wr_index] <= ctrl.wr_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_start  <= start_mem[ctrl.rd_index];
      rd_handle <= handle_mem[ctrl.rd_index];
    end
  end

endmodule
